// ===== sv/sector_cache_clock_replacement_assert.svh =====
// Assertion macros for the sector cache replacement controller.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_ASSERT_SVH

// Check a property on every edge outside reset.
`define SCCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define SCCR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/sccr_pkg.sv =====
// Shared constants and types for the sector cache replacement controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sccr_pkg;

	localparam int SLOTS_DEF = 4;

	localparam int SEC_W   = 32;
	localparam int SLOT_W  = 2;
	localparam int SIU_W   = 3;
	localparam int SLOTS_IN_USE_RST = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SECTOR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd2;

	localparam logic MODE_ACCESS = 1'b0;
	localparam logic MODE_MARK   = 1'b1;

	// slave tdata: sector, slot_to_mark
	localparam int IN_FIELDS_W = SEC_W + SLOT_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

	// master tdata: slot, hit, writeback, writeback_sector, fill, fill_sector
	localparam int OUT_FIELDS_W = SLOT_W + 1 + 1 + SEC_W + 1 + SEC_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CMP,
		S_SWEEP1,
		S_SWEEP2,
		S_VREAD,
		S_VWB,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== sv/sector_cache_clock_replacement.sv =====
// Top level of the sector cache tag and replacement controller.
// Depends on sccr_pkg, sccr_ram and sector_cache_clock_replacement_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sector_cache_clock_replacement_assert.svh"

// Tag lookup and second-chance clock replacement for a SLOTS-entry sector cache.
// Tags live in a small RAM with registered read; valid, reference and dirty bits
// and the clock hand sit in flip-flops. An item is handled one at a time: a mark
// item goes straight to the result; an access reads and compares one tag at a
// time until it hits (up to slots in use), and on a miss the sweeps visit one
// slot per cycle starting at the clock hand, followed by a read and rewrite of
// the victim tag before the result is posted. A finished result waits in an
// output register while the next item is accepted.
module sector_cache_clock_replacement #(
	parameter int SLOTS = sccr_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sccr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sccr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sccr_pkg::IN_TDATA_W-1:0]  s_tdata,  // sector, slot_to_mark
	input  logic                             s_tuser,  // mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sccr_pkg::OUT_TDATA_W-1:0] m_tdata   // slot, hit, writeback,
	                                                   // writeback_sector, fill,
	                                                   // fill_sector
);

	import sccr_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	state_t state_q, state_d;

	logic [SEC_W-1:0] base_q;
	logic [SIU_W-1:0] slots_q;

	logic [SLOTS-1:0] valid_q, ref_q, dirty_q;
	logic [IW-1:0]    hand_q;
	logic [IW-1:0]    victim_q;
	logic [CW-1:0]    idx_q;
	logic [SEC_W-1:0] sec_q;

	logic [SLOT_W-1:0] res_slot_q;
	logic              res_hit_q, res_wb_q, res_fill_q;
	logic [SEC_W-1:0]  res_wbsec_q, res_fsec_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [CW-1:0]    n_act;
	logic [IW-1:0]    ix;
	logic [IW-1:0]    hand_next;
	logic             accept, fin_load, last_scan, hit_now, idx_out, cand;
	logic [SEC_W-1:0] in_sector;
	logic [SLOT_W-1:0] in_mark;
	logic [IW-1:0]    mark_ix;
	logic             mark_ok;
	logic             ram_we;
	logic [IW-1:0]    ram_raddr;
	logic [SEC_W-1:0] ram_rdata;

	assign in_sector = s_tdata[SEC_W-1:0];
	assign in_mark   = s_tdata[SEC_W+SLOT_W-1:SEC_W];
	assign mark_ix   = IW'(in_mark);
	assign mark_ok   = (32'(in_mark) < SLOTS) && valid_q[mark_ix];

	assign n_act = (slots_q == '0) ? CW'(1) :
		((32'(slots_q) > SLOTS) ? CW'(SLOTS) : CW'(slots_q));

	assign ix        = idx_q[IW-1:0];
	assign hand_next = ((idx_q + 1'b1) == n_act) ? '0 : IW'(idx_q + 1'b1);
	assign hit_now   = valid_q[ix] && (ram_rdata == sec_q);
	assign last_scan = (idx_q + 1'b1) >= n_act;
	assign idx_out   = idx_q >= n_act;
	assign cand      = !ref_q[ix] && !dirty_q[ix];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign fin_load = (state_q == S_FIN) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign ram_we    = (state_q == S_VWB);
	assign ram_raddr = (state_q == S_VREAD) ? victim_q : ix;

	sccr_ram #(
		.WIDTH(SEC_W),
		.DEPTH(SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (victim_q),
		.wdata (sec_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == MODE_MARK) ? S_FIN : S_SCAN;
				end
			end
			S_SCAN: state_d = S_CMP;
			S_CMP: begin
				if (hit_now) begin
					state_d = S_FIN;
				end else if (last_scan) begin
					state_d = S_SWEEP1;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SWEEP1: begin
				if (idx_out) begin
					state_d = S_SWEEP2;
				end else if (cand) begin
					state_d = S_VREAD;
				end
			end
			S_SWEEP2: begin
				if (idx_out || cand) begin
					state_d = S_VREAD;
				end
			end
			S_VREAD: state_d = S_VWB;
			S_VWB:   state_d = S_FIN;
			S_FIN: begin
				if (fin_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			slots_q <= SIU_W'(SLOTS_IN_USE_RST);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BASE_SECTOR:  base_q  <= cfg_data[SEC_W-1:0];
				REG_SLOTS_IN_USE: slots_q <= cfg_data[SIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ref_q    <= '0;
			dirty_q  <= '0;
			hand_q   <= '0;
			idx_q    <= '0;
			victim_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept && (s_tuser == MODE_MARK) && mark_ok) begin
						dirty_q[mark_ix] <= 1'b1;
					end
				end
				S_CMP: begin
					if (hit_now) begin
						ref_q[ix] <= 1'b1;
					end else if (last_scan) begin
						idx_q <= CW'(hand_q);
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SWEEP1: begin
					if (idx_out) begin
						idx_q <= '0;
					end else if (ref_q[ix]) begin
						ref_q[ix] <= 1'b0;
						idx_q     <= idx_q + 1'b1;
					end else if (!dirty_q[ix]) begin
						victim_q <= ix;
						hand_q   <= hand_next;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SWEEP2: begin
					if (idx_out) begin
						victim_q <= IW'(n_act - 1'b1);
						hand_q   <= '0;
					end else if (cand) begin
						victim_q <= ix;
						hand_q   <= hand_next;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_VWB: begin
					valid_q[victim_q] <= 1'b1;
					ref_q[victim_q]   <= 1'b1;
					dirty_q[victim_q] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sec_q <= in_sector;
				if (accept) begin
					res_slot_q  <= in_mark;
					res_hit_q   <= mark_ok;
					res_wb_q    <= 1'b0;
					res_wbsec_q <= '0;
					res_fill_q  <= 1'b0;
					res_fsec_q  <= '0;
				end
			end
			S_CMP: begin
				if (hit_now) begin
					res_slot_q <= SLOT_W'(idx_q);
					res_hit_q  <= 1'b1;
				end
			end
			S_VWB: begin
				res_slot_q  <= SLOT_W'(victim_q);
				res_hit_q   <= 1'b0;
				res_wb_q    <= valid_q[victim_q] && dirty_q[victim_q];
				res_wbsec_q <= (valid_q[victim_q] && dirty_q[victim_q]) ?
					(base_q + ram_rdata) : '0;
				res_fill_q  <= 1'b1;
				res_fsec_q  <= base_q + sec_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, res_fsec_q, res_fill_q, res_wbsec_q,
				res_wb_q, res_hit_q, res_slot_q};
		end
	end

	`SCCR_ASSERT(a_hit_no_fill, m_tvalid |-> !(m_tdata[2] && m_tdata[36]), "hit with fill")
	`SCCR_ASSERT(a_wb_has_fill, (m_tvalid && m_tdata[3]) |-> m_tdata[36], "writeback without fill")
	`SCCR_ASSERT_NEXT(a_victim_valid, ram_we, valid_q[victim_q] && ref_q[victim_q] && !dirty_q[victim_q], "victim bits not set after fill")

endmodule

`default_nettype wire

// ===== sv/sccr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sccr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
